@@ hw/rtl/aac_pkg.sv @@
// Shared types, constants and the exp(-x) table for the annealing acceptance block.
// No dependencies; imported by the top, aac_ctrl and aac_dpath, and by the testbench.
package aac_pkg;

  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_AW          = $clog2(EXP_TABLE_DEPTH);
  localparam int STEP_W          = 5;
  localparam int SUG_BITS        = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_START_TEMP = 3'd0,
    REG_COOLING    = 3'd1,
    REG_STAGES     = 3'd2,
    REG_MOVES      = 3'd3,
    REG_MINIMIZE   = 3'd4
  } cfg_reg_e;

  typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

  // Entry i = exp(-16*i/depth) in Q0.16, series in Q2.30 then repeated product
  function automatic exp_tab_t build_exp_table();
    logic [63:0] one;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] e;
    exp_tab_t    t;
    one  = 64'd1 << 30;
    a    = (64'd16 << 30) / EXP_TABLE_DEPTH;
    term = one;
    pos  = one;
    neg  = 64'd0;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * a) >> 30) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    r = pos - neg;
    v = one;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      e = (v + 64'd8192) >> 14;
      t[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
      v = (v * r) >> 30;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic lookup;
    logic apply;
    logic mul;
    logic stage;
    logic check;
    logic sug_step;
    logic out_load;
  } aac_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_init;
    logic is_ignore;
    logic need_div;
    logic roll;
    logic sug_needed;
    logic step_last_div;
    logic step_last_sug;
  } aac_status_t;

endpackage

@@ hw/rtl/annealing_acceptance_controller.sv @@
// Annealing acceptance controller: Metropolis move acceptance in Q16.16.
// Initial or ignored moves go from evaluation straight to the final check; trial moves
// may add the 8-step index divider, table lookup and cooling multiply; the suggestion
// divider runs when finished with non-improving moves seen. One transaction at a time,
// next input taken the cycle after the result loads, even while that result waits.
// Reset (async, active low): default configuration, zero costs and counters.
module annealing_acceptance_controller import aac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] move_cost_i,
  input  logic [15:0]        random_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               move_accepted_o,
  output logic               restore_previous_o,
  output logic               save_best_o,
  output logic               restore_best_o,
  output logic               finished_o,
  output logic [31:0]        current_temperature_o,
  output logic signed [31:0] best_cost_out_o,
  output logic [31:0]        suggested_start_temperature_o
);

  aac_cmd_t    cmd;
  aac_status_t status;

  aac_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .status_i(status), .cmd_o(cmd)
  );

  aac_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .req_type_i, .move_cost_i, .random_value_i,
    .cmd_i(cmd), .status_o(status),
    .move_accepted_o, .restore_previous_o, .save_best_o, .restore_best_o,
    .finished_o, .current_temperature_o, .best_cost_out_o,
    .suggested_start_temperature_o
  );

endmodule

@@ hw/rtl/aac_ctrl.sv @@
// Sequencer for the annealing acceptance block: walks one transaction through
// evaluation, index division, table lookup, cooling and suggestion. Uses aac_pkg.
module aac_ctrl import aac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  aac_status_t status_i,
  output aac_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_DIV, ST_LOOK, ST_APPLY, ST_MUL, ST_STAGE, ST_CHK, ST_SUG, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_take;
  logic   out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_take     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        if (status_i.is_init || status_i.is_ignore) state_d = ST_CHK;
        else if (status_i.need_div) state_d = ST_DIV;
        else state_d = ST_APPLY;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.step_last_div) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = status_i.roll ? ST_MUL : ST_CHK;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_STAGE;
      end
      ST_STAGE: begin
        cmd_o.stage = 1'b1;
        state_d     = ST_CHK;
      end
      ST_CHK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.sug_needed ? ST_SUG : ST_DONE;
      end
      ST_SUG: begin
        cmd_o.sug_step = 1'b1;
        if (status_i.step_last_sug) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/aac_dpath.sv @@
// Datapath of the annealing acceptance block: configuration, annealing state,
// index and suggestion dividers, cooling multiplier, result registers. Uses aac_pkg.
module aac_dpath import aac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               req_type_i,
  input  logic signed [31:0] move_cost_i,
  input  logic [15:0]        random_value_i,
  input  aac_cmd_t           cmd_i,
  output aac_status_t        status_o,
  output logic               move_accepted_o,
  output logic               restore_previous_o,
  output logic               save_best_o,
  output logic               restore_best_o,
  output logic               finished_o,
  output logic [31:0]        current_temperature_o,
  output logic signed [31:0] best_cost_out_o,
  output logic [31:0]        suggested_start_temperature_o
);

  // Configuration registers
  logic [31:0] start_temp_q;
  logic [15:0] cooling_q, stages_q, moves_q;
  logic        minimize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_temp_q <= 32'd65536;
      cooling_q    <= 16'd58982;
      stages_q     <= 16'd16;
      moves_q      <= 16'd256;
      minimize_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_TEMP: start_temp_q <= cfg_data_i;
        REG_COOLING:    cooling_q    <= cfg_data_i[15:0];
        REG_STAGES:     stages_q     <= cfg_data_i[15:0];
        REG_MOVES:      moves_q      <= cfg_data_i[15:0];
        REG_MINIMIZE:   minimize_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Latched transaction and annealing state
  logic               req_q;
  logic signed [31:0] cost_q, prev_q, best_q;
  logic [15:0]        rnd_q;
  logic [31:0]        temp_q;
  logic [15:0]        mc_q, sc_q;
  logic [47:0]        sum_q;
  logic [31:0]        cnt_q;
  logic               ok_q, acc_q, undo_q, save_q, rbest_q;
  logic [31:0]        rem_q;
  logic [EXP_AW-1:0]  nlo_q, quot_q;
  logic [STEP_W-1:0]  step_q;
  logic [47:0]        prod_q;
  logic [35:0]        srem_q;
  logic [31:0]        snum_q, squot_q;
  logic               sat_q, szero_q;

  // Evaluation terms
  logic        better_prev, better_best, w_big, fin;
  logic [32:0] diff;
  logic [31:0] w;
  logic [15:0] mc_next;
  logic        roll;
  logic [32:0] dv_t;
  logic        dv_ge;
  logic [53:0] snum_full;
  logic [35:0] sden;
  logic [36:0] sg_t;
  logic        sg_ge;

  assign better_prev = minimize_q ? (cost_q < prev_q) : (cost_q > prev_q);
  assign better_best = minimize_q ? (cost_q < best_q) : (cost_q > best_q);
  assign diff = minimize_q ? ({cost_q[31], cost_q} - {prev_q[31], prev_q})
                           : ({prev_q[31], prev_q} - {cost_q[31], cost_q});
  assign w       = diff[31:0];
  assign w_big   = {4'b0, w} >= {temp_q, 4'b0};
  assign fin     = sc_q >= stages_q;
  assign mc_next = mc_q + 16'd1;
  assign roll    = (mc_next == 16'd0) || (mc_next >= moves_q);

  // Index divider step: one quotient bit of w*depth/(16*T)
  assign dv_t  = {rem_q, nlo_q[EXP_AW-1]};
  assign dv_ge = dv_t >= {1'b0, temp_q};

  // Suggestion divider: sum*50 / (count*11), one quotient bit per step
  assign snum_full = {1'b0, sum_q, 5'b0} + {2'b0, sum_q, 4'b0} + {5'b0, sum_q, 1'b0};
  assign sden  = {1'b0, cnt_q, 3'b0} + {3'b0, cnt_q, 1'b0} + {4'b0, cnt_q};
  assign sg_t  = {srem_q, snum_q[SUG_BITS-1]};
  assign sg_ge = sg_t >= {1'b0, sden};

  always_comb begin
    status_o               = '0;
    status_o.is_init       = !req_q;
    status_o.is_ignore     = req_q && fin;
    status_o.need_div      = req_q && !fin && !better_prev && (w != 32'd0) && !w_big;
    status_o.roll          = roll;
    status_o.sug_needed    = fin && (cnt_q != 32'd0);
    status_o.step_last_div = step_q == STEP_W'(EXP_AW - 1);
    status_o.step_last_sug = step_q == STEP_W'(SUG_BITS - 1);
  end

  // State updates by command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      best_q  <= '0;
      temp_q  <= 32'd65536;
      mc_q    <= '0;
      sc_q    <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.eval) begin
        if (!req_q) begin
          prev_q <= cost_q;
          best_q <= cost_q;
          temp_q <= start_temp_q;
          mc_q   <= '0;
          sc_q   <= '0;
          sum_q  <= '0;
          cnt_q  <= '0;
        end else if (!fin && !better_prev) begin
          if ({16'b0, w} >= ~sum_q) sum_q <= '1;
          else sum_q <= sum_q + {16'b0, w};
          if (cnt_q != '1) cnt_q <= cnt_q + 32'd1;
        end
      end
      if (cmd_i.apply) begin
        if (ok_q) begin
          prev_q <= cost_q;
          if (better_best) best_q <= cost_q;
        end
        if (roll) begin
          mc_q <= '0;
          sc_q <= sc_q + 16'd1;
        end else begin
          mc_q <= mc_next;
        end
      end
      if (cmd_i.stage) begin
        temp_q <= prod_q[47:16];
        prev_q <= best_q;
      end
    end
  end

  // Transaction scratch, flags and dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= 1'b0;
      ok_q    <= 1'b0;
      acc_q   <= 1'b0;
      undo_q  <= 1'b0;
      save_q  <= 1'b0;
      rbest_q <= 1'b0;
      step_q  <= '0;
      sat_q   <= 1'b0;
      szero_q <= 1'b1;
    end else begin
      if (cmd_i.load) begin
        req_q   <= req_type_i;
        acc_q   <= 1'b0;
        undo_q  <= 1'b0;
        save_q  <= 1'b0;
        rbest_q <= 1'b0;
      end
      if (cmd_i.eval) begin
        step_q <= '0;
        if (!req_q) save_q <= 1'b1;
        else if (fin) undo_q <= 1'b1;
        else if (better_prev || (w == 32'd0)) ok_q <= 1'b1;
        else ok_q <= 1'b0;
      end
      if (cmd_i.div_step) step_q <= step_q + STEP_W'(1);
      if (cmd_i.lookup) ok_q <= rnd_q < EXP_TABLE[quot_q];
      if (cmd_i.apply) begin
        acc_q   <= ok_q;
        undo_q  <= !ok_q;
        save_q  <= ok_q && better_best;
        rbest_q <= roll;
      end
      if (cmd_i.check) begin
        step_q  <= '0;
        sat_q   <= {14'b0, snum_full[53:32]} >= sden;
        szero_q <= !(fin && (cnt_q != 32'd0));
      end
      if (cmd_i.sug_step) step_q <= step_q + STEP_W'(1);
    end
  end

  // Payload registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cost_q <= move_cost_i;
      rnd_q  <= random_value_i;
    end
    if (cmd_i.eval) begin
      rem_q <= {4'b0, w[31:4]};
      nlo_q <= {w[3:0], {(EXP_AW - 4){1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_q  <= dv_ge ? (dv_t[31:0] - temp_q) : dv_t[31:0];
      quot_q <= {quot_q[EXP_AW-2:0], dv_ge};
      nlo_q  <= {nlo_q[EXP_AW-2:0], 1'b0};
    end
    if (cmd_i.mul) prod_q <= temp_q * cooling_q;
    if (cmd_i.check) begin
      srem_q <= {14'b0, snum_full[53:32]};
      snum_q <= snum_full[31:0];
    end
    if (cmd_i.sug_step) begin
      srem_q  <= sg_ge ? (sg_t[35:0] - sden) : sg_t[35:0];
      snum_q  <= {snum_q[SUG_BITS-2:0], 1'b0};
      squot_q <= {squot_q[SUG_BITS-2:0], sg_ge};
    end
    if (cmd_i.out_load) begin
      move_accepted_o       <= acc_q;
      restore_previous_o    <= undo_q;
      save_best_o           <= save_q;
      restore_best_o        <= rbest_q;
      finished_o            <= fin;
      current_temperature_o <= temp_q;
      best_cost_out_o       <= best_q;
      suggested_start_temperature_o <= szero_q ? 32'd0 : (sat_q ? '1 : squot_q);
    end
  end

endmodule

@@ hw/rtl/aac_checker.sv @@
// Port-level checks for the annealing acceptance controller, bound to the top.
// Uses only the top level's ports.
module aac_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic move_accepted_o,
  input logic restore_previous_o,
  input logic save_best_o,
  input logic finished_o,
  input logic [31:0] suggested_start_temperature_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped under stall");

  // One transaction in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // Keep and undo are exclusive
  a_keep_undo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(move_accepted_o && restore_previous_o))
    else $error("accepted and undone together");

  // A new best is never undone
  a_save_undo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && save_best_o |-> !restore_previous_o)
    else $error("save with undo");

  // Suggestion is zero until finished
  a_sug_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |-> suggested_start_temperature_o == 32'd0)
    else $error("suggestion before finish");

endmodule

bind annealing_acceptance_controller aac_checker u_aac_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .move_accepted_o, .restore_previous_o, .save_best_o, .finished_o,
  .suggested_start_temperature_o
);

@@ tb/sv/tb_annealing_acceptance_controller.sv @@
// Testbench for annealing_acceptance_controller: Metropolis acceptance, cooling, best tracking.
// Depends on aac_pkg (register indexes) and the RTL; a scoreboard class predicts each result.
module tb_annealing_acceptance_controller;
  import aac_pkg::*;

  localparam int TBL_DEPTH = 256;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  // One result transaction
  typedef struct packed {
    logic        accepted;
    logic        undo;
    logic        save;
    logic        rbest;
    logic        fin;
    logic [31:0] temp;
    logic [31:0] best;
    logic [31:0] sugg;
  } decision_t;

  // Predicts decisions and holds the ones not yet seen
  class decision_board;
    logic [15:0] exp_lut [TBL_DEPTH];
    logic [31:0] t0;
    logic [15:0] cool, stages, moves;
    logic        minimize;
    logic [31:0] temp;
    logic [31:0] prev_key, best_key;
    logic [15:0] move_cnt, stage_cnt;
    logic [47:0] wsum;
    logic [31:0] wcnt;
    decision_t   pending[$];
    int          errors;
    int          checked;

    function new();
      logic [63:0] one, a, term, pos, neg, r, v, e;
      one = 64'd1 << 30;
      a = (64'd16 << 30) / TBL_DEPTH;
      term = one;
      pos = one;
      neg = 0;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * a) >> 30) / k;
        if (k % 2) neg += term;
        else pos += term;
      end
      r = pos - neg;
      v = one;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        e = (v + 64'd8192) >> 14;
        exp_lut[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        v = (v * r) >> 30;
      end
      t0 = 32'd65536;
      cool = 16'd58982;
      stages = 16'd16;
      moves = 16'd256;
      minimize = 1'b1;
      temp = t0;
      prev_key = 32'h8000_0000;
      best_key = 32'h8000_0000;
      move_cnt = 0;
      stage_cnt = 0;
      wsum = 0;
      wcnt = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] d);
      case (idx)
        REG_START_TEMP: t0 = d;
        REG_COOLING:    cool = d[15:0];
        REG_STAGES:     stages = d[15:0];
        REG_MOVES:      moves = d[15:0];
        REG_MINIMIZE:   minimize = d[0];
        default: ;
      endcase
    endfunction

    function bit is_better(logic [31:0] a, logic [31:0] b);
      return minimize ? (a < b) : (a > b);
    endfunction

    // Note an accepted input transaction and queue its decision
    function void note_move(logic kind, logic [31:0] cost, logic [15:0] rnd);
      decision_t   d;
      logic [31:0] key;
      logic [31:0] w;
      logic [36:0] span;
      logic [63:0] q;
      bit          ok;
      d = '0;
      key = cost ^ 32'h8000_0000;
      if (!kind) begin
        prev_key = key;
        best_key = key;
        temp = t0;
        move_cnt = 0;
        stage_cnt = 0;
        wsum = 0;
        wcnt = 0;
        d.save = 1;
      end else if (stage_cnt >= stages) begin
        d.undo = 1;
      end else begin
        if (is_better(key, prev_key)) begin
          ok = 1;
        end else begin
          w = minimize ? key - prev_key : prev_key - key;
          span = {5'd0, temp} * 37'd16;
          if (48'(w) >= SUM_MAX - wsum) wsum = SUM_MAX;
          else wsum += 48'(w);
          if (wcnt != 32'hFFFF_FFFF) wcnt++;
          if (w == 0) ok = 1;
          else if (temp == 0 || 37'(w) >= span) ok = 0;
          else ok = rnd < exp_lut[(64'(w) * TBL_DEPTH) / 64'(span)];
        end
        if (ok) begin
          d.accepted = 1;
          prev_key = key;
          if (is_better(key, best_key)) begin
            best_key = key;
            d.save = 1;
          end
        end else begin
          d.undo = 1;
        end
        move_cnt++;
        if (move_cnt == 0 || move_cnt >= moves) begin
          move_cnt = 0;
          stage_cnt++;
          temp = 32'((64'(temp) * 64'(cool)) >> 16);
          prev_key = best_key;
          d.rbest = 1;
        end
      end
      d.fin = stage_cnt >= stages;
      d.temp = temp;
      d.best = best_key ^ 32'h8000_0000;
      if (d.fin && wcnt != 0) begin
        q = (64'(wsum) * 64'd50) / (64'(wcnt) * 64'd11);
        d.sugg = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
      pending.push_back(d);
    endfunction

    function void check_decision(decision_t got);
      decision_t x;
      checked++;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.accepted !== x.accepted) begin
        $error("move_accepted exp %0d got %0d", x.accepted, got.accepted); errors++;
      end
      if (got.undo !== x.undo) begin
        $error("restore_previous exp %0d got %0d", x.undo, got.undo); errors++;
      end
      if (got.save !== x.save) begin
        $error("save_best exp %0d got %0d", x.save, got.save); errors++;
      end
      if (got.rbest !== x.rbest) begin
        $error("restore_best exp %0d got %0d", x.rbest, got.rbest); errors++;
      end
      if (got.fin !== x.fin) begin
        $error("finished exp %0d got %0d", x.fin, got.fin); errors++;
      end
      if (got.temp !== x.temp) begin
        $error("current_temperature exp %h got %h", x.temp, got.temp); errors++;
      end
      if (got.best !== x.best) begin
        $error("best_cost_out exp %h got %h", x.best, got.best); errors++;
      end
      if (got.sugg !== x.sugg) begin
        $error("suggested_start_temperature exp %h got %h", x.sugg, got.sugg); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic        req_type;
  logic signed [31:0] move_cost;
  logic [15:0] random_value;
  logic        out_valid, out_stall;
  decision_t   seen;

  decision_board board;
  int  send_idle_pct, recv_stall_pct;
  bit  hold_off;
  int  sent;

  annealing_acceptance_controller DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .move_cost_i(move_cost), .random_value_i(random_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .move_accepted_o(seen.accepted), .restore_previous_o(seen.undo),
    .save_best_o(seen.save), .restore_best_o(seen.rbest), .finished_o(seen.fin),
    .current_temperature_o(seen.temp), .best_cost_out_o(seen.best),
    .suggested_start_temperature_o(seen.sugg)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check every result transaction at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_decision(seen);
  end

  // Offer one transaction, with random idle gaps before it; valid stays up
  // after acceptance so the next offer can follow back to back
  task automatic send_move(logic kind, logic [31:0] cost, logic [15:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    move_cost <= cost;
    random_value <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_move(kind, cost, rnd);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, d);
    @(negedge clk);
  endtask

  // Costs near the previous one most of the time, so acceptance is exercised
  function automatic logic [31:0] near_cost(logic [31:0] base);
    case ($urandom_range(9))
      0: return $urandom;
      1: return base;
      default: return base + 32'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  // One annealing run: initial item then random trial moves
  task automatic run_session(int n);
    logic [31:0] c;
    c = $urandom;
    send_move(1'b0, c, $urandom);
    for (int i = 0; i < n; i++) begin
      c = near_cost(c);
      send_move(1'b1, c, $urandom);
    end
  endtask

  initial begin
    int ph;
    board = new();
    rst_n = 0;
    cfg_we = 0; cfg_index = REG_START_TEMP; cfg_data = 0;
    in_valid = 0; req_type = 0; move_cost = 0; random_value = 0;
    out_stall = 0; hold_off = 0;
    send_idle_pct = 0; recv_stall_pct = 0; sent = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: move before any initial item, extremes, equal cost, zero temp
    send_move(1'b1, 32'h0000_0010, 16'h0000);
    send_move(1'b0, 32'h7FFF_FFFF, 16'hFFFF);
    send_move(1'b1, 32'h8000_0000, 16'h0000);
    send_move(1'b1, 32'h8000_0000, 16'hFFFF);
    send_move(1'b0, 32'h0001_0000, 16'h0);
    send_move(1'b1, 32'h0001_0000, 16'hFFFF);
    send_move(1'b1, 32'h0001_8000, 16'h0000);
    send_move(1'b1, 32'h0011_0000, 16'h0000);
    send_move(1'b1, 32'hFFFF_0000, 16'h1234);
    drain();
    write_cfg(REG_START_TEMP, 32'd0);
    write_cfg(REG_COOLING, 32'd0);
    write_cfg(REG_STAGES, 32'd0);
    write_cfg(REG_MOVES, 32'd0);
    write_cfg(REG_MINIMIZE, 32'd0);
    send_move(1'b0, 32'h0, 16'h0);
    send_move(1'b1, 32'h5, 16'h0);
    drain();
    write_cfg(REG_STAGES, 32'd2);
    send_move(1'b0, 32'h0010_0000, 16'h0);
    send_move(1'b1, 32'h0000_0000, 16'h0);
    send_move(1'b1, 32'h0020_0000, 16'h0);
    send_move(1'b1, 32'h0030_0000, 16'h0);
    drain();

    // Random phases, rotating idling and configuration
    for (ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (ph % 5)
        0: write_cfg(REG_START_TEMP, 32'hFFFF_FFFF);
        1: write_cfg(REG_START_TEMP, 32'd1);
        default: write_cfg(REG_START_TEMP, $urandom_range(32'h0040_0000, 32'h0000_4000));
      endcase
      write_cfg(REG_COOLING, (ph == 3) ? 32'd65535 : $urandom_range(65535, 30000));
      write_cfg(REG_STAGES, (ph == 7) ? 32'd65535 : $urandom_range(6, 1));
      write_cfg(REG_MOVES, (ph == 9) ? 32'd65535 : $urandom_range(12, 1));
      write_cfg(REG_MINIMIZE, $urandom_range(1));
      if (ph == 5) begin
        // Long receiver hold-off while the sender keeps offering
        fork
          begin
            hold_off = 1;
            repeat (300) @(negedge clk);
            hold_off = 0;
          end
          run_session(43);
        join
      end else begin
        run_session(48);
      end
      drain();
    end

    $display("Covered %0d transactions over 16 random phases plus directed corner cases,",
             sent);
    $display("checking %0d decisions in both optimization modes.", board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
